// ===== src/pgmp_pkg.sv =====
// Package for the PGM stream parser: job record, error codes, byte codes
// and default sizes. Used by every module of the parser; depends on nothing.
`default_nettype none
package pgmp_pkg;

  localparam int TOKEN_MAX_DEFAULT = 255;
  localparam int DIM_BITS_DEFAULT  = 16;
  localparam int QUEUE_DEPTH       = 2;
  localparam int VAL_BITS          = 17;
  localparam int DIVIDEND_BITS     = 25;
  localparam logic [VAL_BITS-1:0] VAL_SAT = 17'd131071;

  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [15:0] MAX_UNSCALED = 16'd255;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  typedef enum logic [2:0] {
    ERR_BAD_MAGIC    = 3'd0,
    ERR_NO_SPACE     = 3'd1,
    ERR_BAD_HEADER   = 3'd2,
    ERR_TOKEN_LONG   = 3'd3,
    ERR_EARLY_END    = 3'd4,
    ERR_NEG_PIXEL    = 3'd5
  } err_code_t;

  typedef struct packed {
    logic                kind;
    err_code_t           code;
    logic [VAL_BITS-1:0] value;
    logic                scale;
    logic [15:0]         max_level;
    logic [15:0]         column;
    logic [15:0]         row;
    logic                last;
  } job_t;

endpackage
`default_nettype wire

// ===== src/pgmp_front.sv =====
// Front part of the PGM parser: magic check, header tokens, comment and
// whitespace handling, pixel position. Emits jobs; depends on pgmp_pkg.
`default_nettype none
module pgmp_front #(
  parameter int TOKEN_MAX = pgmp_pkg::TOKEN_MAX_DEFAULT,
  parameter int DIM_BITS  = pgmp_pkg::DIM_BITS_DEFAULT
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [7:0]    data_byte,
  input  wire logic          end_of_stream,
  output logic               job_push,
  output pgmp_pkg::job_t     job
);

  localparam int TLW = $clog2(TOKEN_MAX + 1);
  localparam logic [pgmp_pkg::VAL_BITS-1:0] DIM_MAX =
    pgmp_pkg::VAL_BITS'((1 << DIM_BITS) - 1);

  typedef enum logic [3:0] {
    PH_M0, PH_M1, PH_M2, PH_M1BAD, PH_M2BAD, PH_WIDTH, PH_HEIGHT, PH_MAXV,
    PH_DRAIN, PH_ASCII, PH_BIN, PH_DONE, PH_ERR
  } phase_t;

  phase_t phase, phase_next;
  logic binary_mode, binary_mode_next;
  logic in_comment, in_comment_next;
  logic [pgmp_pkg::VAL_BITS-1:0] token_value, token_value_next;
  logic [TLW-1:0] token_length, token_length_next;
  logic token_negative, token_negative_next;
  logic token_stopped, token_stopped_next;
  logic ended_on_newline, ended_on_newline_next;
  logic [DIM_BITS-1:0] image_width, image_width_next;
  logic [DIM_BITS-1:0] image_height, image_height_next;
  logic [15:0] max_level, max_level_next;
  logic [15:0] column_count, column_count_next;
  logic [15:0] row_count, row_count_next;

  logic is_ws, tok_phase, fin_req, fin_eos, fin_nl, err_req, pix_req, pix_scale;
  logic final_pix, neg, bad;
  pgmp_pkg::err_code_t err_code;
  logic [pgmp_pkg::VAL_BITS-1:0] pix_val, v;
  logic [TLW-1:0] len_inc;
  logic [20:0] acc;
  logic [16:0] col_inc;

  always_comb begin
    phase_next = phase;
    binary_mode_next = binary_mode;
    in_comment_next = in_comment;
    token_value_next = token_value;
    token_length_next = token_length;
    token_negative_next = token_negative;
    token_stopped_next = token_stopped;
    ended_on_newline_next = ended_on_newline;
    image_width_next = image_width;
    image_height_next = image_height;
    max_level_next = max_level;
    column_count_next = column_count;
    row_count_next = row_count;
    fin_req = 1'b0;
    fin_eos = 1'b0;
    fin_nl = 1'b0;
    err_req = 1'b0;
    err_code = pgmp_pkg::ERR_BAD_MAGIC;
    pix_req = 1'b0;
    pix_val = '0;
    pix_scale = 1'b0;
    neg = 1'b0;
    bad = 1'b0;
    v = token_value;
    is_ws = (data_byte == pgmp_pkg::CH_SPACE) ||
            (data_byte >= pgmp_pkg::CH_TAB && data_byte <= pgmp_pkg::CH_CR);
    tok_phase = (phase == PH_WIDTH) || (phase == PH_HEIGHT) ||
                (phase == PH_MAXV) || (phase == PH_ASCII);
    len_inc = token_length + TLW'(1);
    acc = 21'(token_value) * 21'd10 + 21'(data_byte - pgmp_pkg::CH_ZERO);
    col_inc = {1'b0, column_count} + 17'd1;
    final_pix = (row_count == 16'd0) && (col_inc >= 17'(image_width));

    if (accept && phase != PH_DONE && phase != PH_ERR) begin
      if (end_of_stream) begin
        if (tok_phase && token_length != '0) begin
          fin_req = 1'b1;
          fin_eos = 1'b1;
        end else begin
          err_req = 1'b1;
          err_code = pgmp_pkg::ERR_EARLY_END;
        end
      end else begin
        case (phase)
          PH_M0: phase_next = (data_byte == pgmp_pkg::CH_P) ? PH_M1 : PH_M1BAD;
          PH_M1: begin
            if (data_byte == pgmp_pkg::CH_TWO || data_byte == pgmp_pkg::CH_FIVE) begin
              binary_mode_next = (data_byte == pgmp_pkg::CH_FIVE);
              phase_next = PH_M2;
            end else begin
              phase_next = PH_M2BAD;
            end
          end
          PH_M1BAD: phase_next = PH_M2BAD;
          PH_M2BAD: err_req = 1'b1;
          PH_M2: begin
            if (!is_ws) begin
              err_req = 1'b1;
              err_code = pgmp_pkg::ERR_NO_SPACE;
            end else begin
              phase_next = PH_WIDTH;
            end
          end
          PH_DRAIN: if (data_byte == pgmp_pkg::CH_LF) phase_next = PH_BIN;
          PH_BIN: begin
            pix_req = 1'b1;
            pix_val = pgmp_pkg::VAL_BITS'(data_byte);
          end
          PH_WIDTH, PH_HEIGHT, PH_MAXV, PH_ASCII: begin
            // Inside a comment only the newline matters; it then acts as whitespace.
            if (in_comment && data_byte != pgmp_pkg::CH_LF) begin
              in_comment_next = 1'b1;
            end else if (!in_comment && data_byte == pgmp_pkg::CH_HASH) begin
              in_comment_next = 1'b1;
            end else begin
              in_comment_next = 1'b0;
              if (is_ws) begin
                if (token_length != '0) begin
                  fin_req = 1'b1;
                  fin_nl = (data_byte == pgmp_pkg::CH_LF);
                end
              end else begin
                token_length_next = len_inc;
                if (len_inc >= TLW'(TOKEN_MAX)) begin
                  err_req = 1'b1;
                  err_code = pgmp_pkg::ERR_TOKEN_LONG;
                end else if (len_inc == TLW'(1) && (data_byte == pgmp_pkg::CH_MINUS ||
                             data_byte == pgmp_pkg::CH_PLUS)) begin
                  token_negative_next = (data_byte == pgmp_pkg::CH_MINUS);
                end else if (!token_stopped && data_byte >= pgmp_pkg::CH_ZERO &&
                             data_byte <= pgmp_pkg::CH_NINE) begin
                  token_value_next = (acc > 21'(pgmp_pkg::VAL_SAT)) ? pgmp_pkg::VAL_SAT
                                     : acc[pgmp_pkg::VAL_BITS-1:0];
                end else begin
                  token_stopped_next = 1'b1;
                end
              end
            end
          end
          default: begin
            err_req = 1'b1;
            err_code = pgmp_pkg::ERR_EARLY_END;
          end
        endcase
      end
    end

    if (fin_req) begin
      neg = token_negative && (token_value != '0);
      token_value_next = '0;
      token_length_next = '0;
      token_negative_next = 1'b0;
      token_stopped_next = 1'b0;
      in_comment_next = 1'b0;
      if (phase == PH_ASCII) begin
        if (neg) begin
          err_req = 1'b1;
          err_code = pgmp_pkg::ERR_NEG_PIXEL;
        end else if (fin_eos && !final_pix) begin
          err_req = 1'b1;
          err_code = pgmp_pkg::ERR_EARLY_END;
        end else begin
          pix_req = 1'b1;
          pix_val = token_value;
          pix_scale = (max_level != pgmp_pkg::MAX_UNSCALED) && (max_level != 16'd0);
        end
      end else begin
        if (phase == PH_MAXV)
          bad = neg || (v == '0) || (v > 17'd65535);
        else
          bad = neg || (v == '0) || (v > DIM_MAX);
        if (bad) begin
          err_req = 1'b1;
          err_code = pgmp_pkg::ERR_BAD_HEADER;
        end else begin
          if (phase == PH_WIDTH) begin
            image_width_next = DIM_BITS'(v);
            phase_next = PH_HEIGHT;
          end else if (phase == PH_HEIGHT) begin
            image_height_next = DIM_BITS'(v);
            phase_next = PH_MAXV;
          end else begin
            max_level_next = v[15:0];
            ended_on_newline_next = fin_nl;
            column_count_next = '0;
            row_count_next = 16'(image_height) - 16'd1;
            if (!binary_mode) phase_next = PH_ASCII;
            else phase_next = fin_nl ? PH_BIN : PH_DRAIN;
          end
          if (fin_eos) begin
            err_req = 1'b1;
            err_code = pgmp_pkg::ERR_EARLY_END;
          end
        end
      end
    end

    if (pix_req) begin
      if (final_pix) begin
        phase_next = PH_DONE;
      end else if (col_inc >= 17'(image_width)) begin
        column_count_next = '0;
        row_count_next = row_count - 16'd1;
      end else begin
        column_count_next = col_inc[15:0];
      end
    end
    if (err_req) phase_next = PH_ERR;

    job_push = err_req || pix_req;
    job.kind = err_req ? pgmp_pkg::KIND_ERROR : pgmp_pkg::KIND_PIXEL;
    job.code = err_req ? err_code : pgmp_pkg::ERR_BAD_MAGIC;
    job.value = err_req ? '0 : pix_val;
    job.scale = pix_scale && !err_req;
    job.max_level = max_level;
    job.column = err_req ? 16'd0 : column_count;
    job.row = err_req ? 16'd0 : row_count;
    job.last = err_req || final_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_M0;
      binary_mode <= 1'b0;
      in_comment <= 1'b0;
      token_value <= '0;
      token_length <= '0;
      token_negative <= 1'b0;
      token_stopped <= 1'b0;
      ended_on_newline <= 1'b0;
      image_width <= '0;
      image_height <= '0;
      max_level <= '0;
      column_count <= '0;
      row_count <= '0;
    end else begin
      phase <= phase_next;
      binary_mode <= binary_mode_next;
      in_comment <= in_comment_next;
      token_value <= token_value_next;
      token_length <= token_length_next;
      token_negative <= token_negative_next;
      token_stopped <= token_stopped_next;
      ended_on_newline <= ended_on_newline_next;
      image_width <= image_width_next;
      image_height <= image_height_next;
      max_level <= max_level_next;
      column_count <= column_count_next;
      row_count <= row_count_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/pgmp_queue.sv =====
// Short job queue between the parser front and the output back end.
// Holds pgmp_pkg::job_t records; depends on pgmp_pkg.
`default_nettype none
module pgmp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  pgmp_pkg::job_t      push_job,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output pgmp_pkg::job_t      head_job
);

  localparam int AW = $clog2(pgmp_pkg::QUEUE_DEPTH);

  pgmp_pkg::job_t entries [pgmp_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0] count;

  assign full = (count == (AW+1)'(pgmp_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + AW'(1);
      if (pop) rd_ptr <= rd_ptr + AW'(1);
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

endmodule
`default_nettype wire

// ===== src/pgmp_back.sv =====
// Back end of the PGM parser: scales ASCII pixels by 255/max with a
// bit-serial restoring divider and holds the output register. Uses pgmp_pkg.
`default_nettype none
module pgmp_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  pgmp_pkg::job_t      head_job,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output pgmp_pkg::job_t      out_job
);

  localparam int CW = $clog2(pgmp_pkg::DIVIDEND_BITS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_WB} state_t;

  state_t state;
  logic [pgmp_pkg::DIVIDEND_BITS-1:0] dividend;
  logic [15:0] remainder;
  logic [7:0] quotient;
  logic [CW-1:0] steps;
  pgmp_pkg::job_t hold;
  logic out_free;
  logic [16:0] rem_shift;
  logic rem_ge;
  logic [pgmp_pkg::DIVIDEND_BITS-1:0] product;
  logic load_direct, load_div;
  pgmp_pkg::job_t direct_job, div_job;

  assign out_free = !out_valid || out_ready;
  assign pop = (state == ST_IDLE) && head_valid && out_free;
  assign load_direct = pop && !head_job.scale;
  assign load_div = (state == ST_WB) && out_free;
  assign rem_shift = {remainder, dividend[pgmp_pkg::DIVIDEND_BITS-1]};
  assign rem_ge = rem_shift >= {1'b0, hold.max_level};
  // v*255 as (v << 8) - v.
  assign product = (pgmp_pkg::DIVIDEND_BITS'(head_job.value) << 8) -
                   pgmp_pkg::DIVIDEND_BITS'(head_job.value);

  always_comb begin
    direct_job = head_job;
    direct_job.value = {9'd0, head_job.value[7:0]};
    div_job = hold;
    div_job.value = {9'd0, quotient};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_direct || load_div) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (load_direct) out_job <= direct_job;
      else if (load_div) out_job <= div_job;
      case (state)
        ST_IDLE: begin
          if (pop) begin
            hold <= head_job;
            if (head_job.scale) begin
              dividend <= product;
              remainder <= '0;
              steps <= CW'(pgmp_pkg::DIVIDEND_BITS);
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          remainder <= rem_ge ? 16'(rem_shift - {1'b0, hold.max_level}) : rem_shift[15:0];
          quotient <= {quotient[6:0], rem_ge};
          dividend <= dividend << 1;
          steps <= steps - CW'(1);
          if (steps == CW'(1)) state <= ST_WB;
        end
        ST_WB: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/pgm_stream_parser_core.sv =====
// Top level of the PGM (P2/P5) stream parser: front parser, job queue and
// scaling back end. Depends on pgmp_pkg, pgmp_front, pgmp_queue, pgmp_back.
//
//   channel | direction | tdata                         | tlast          | tuser
//   s_*     | in        | data_byte                     | end_of_stream  | -
//   m_*     | out       | pixel, column, row, err code  | last           | result_kind
//
// The front takes one byte per cycle while the two-entry job queue has room.
// A binary pixel, an ASCII pixel with max 255, or an error passes from the
// queue straight into the output register; an ASCII pixel with max other than
// 255 first goes through the one-bit-per-cycle divider of the back end, which
// takes no new job from the queue until that pixel is in the output register.
// Reset is synchronous and clears all control state; output stalls back up
// through the queue into s_tready.
`default_nettype none
module pgm_stream_parser_core #(
  parameter int TOKEN_MAX = pgmp_pkg::TOKEN_MAX_DEFAULT,
  parameter int DIM_BITS  = pgmp_pkg::DIM_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
  input  wire logic        s_tlast,   // end_of_stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // pixel_value[7:0], column[23:8], row[39:24],
                                      // error_code[42:40], zero fill
  output logic             m_tlast,   // last
  output logic             m_tuser    // result_kind
);

  logic accept, job_push, q_full, pop, head_valid;
  pgmp_pkg::job_t job, head_job, out_job;

  assign s_tready = !q_full;
  assign accept = s_tvalid && s_tready;

  pgmp_front #(.TOKEN_MAX(TOKEN_MAX), .DIM_BITS(DIM_BITS)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .data_byte(s_tdata),
    .end_of_stream(s_tlast), .job_push(job_push), .job(job)
  );

  pgmp_queue u_queue (
    .clk(clk), .rst(rst), .push(job_push), .push_job(job), .full(q_full),
    .pop(pop), .head_valid(head_valid), .head_job(head_job)
  );

  pgmp_back u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head_job(head_job),
    .pop(pop), .out_valid(m_tvalid), .out_ready(m_tready), .out_job(out_job)
  );

  assign m_tdata = {5'd0, out_job.code, out_job.row, out_job.column, out_job.value[7:0]};
  assign m_tlast = out_job.last;
  assign m_tuser = out_job.kind;

endmodule
`default_nettype wire

// ===== src/pgmp_checker.sv =====
// Port-level checks of the PGM stream parser output, bound to the top level.
// Depends only on the ports of pgm_stream_parser_core.
`default_nettype none
module pgmp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic        m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && m_tdata[39:0] == 40'd0)
    else $error("error result without last or with pixel data");

  a_pix_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[47:40] == 8'd0)
    else $error("pixel result carries an error code");

  a_after_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid)
    else $error("result after the final one");

endmodule

bind pgm_stream_parser_core pgmp_checker u_pgmp_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready),
  .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser)
);
`default_nettype wire
